/* design/circ_pkg.sv */
// circle rasterizer package: widths, codes and register map
`default_nettype none

package circ_pkg;

    // default geometry
    localparam int COORD_WIDTH  = 16;
    localparam int RADIUS_WIDTH = 8;
    localparam int COLOR_WIDTH  = 16;

    // step queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;
    localparam int REG_IDX_WIDTH = PADDR_WIDTH - 2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_PEN_COLOR = 1'b0;

    // item operation codes
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

endpackage

`default_nettype wire

/* design/circ_if.sv */
// item channels of the circle rasterizer: input items and pixel items
`default_nettype none

interface circ_in_if #(
    parameter int COORD_WIDTH  = circ_pkg::COORD_WIDTH,
    parameter int RADIUS_WIDTH = circ_pkg::RADIUS_WIDTH
);
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [COORD_WIDTH-1:0]  center_x;
    logic [COORD_WIDTH-1:0]  center_y;
    logic [RADIUS_WIDTH-1:0] radius;

    modport source (
        output valid, operation, center_x, center_y, radius,
        input  ready
    );
    modport sink (
        input  valid, operation, center_x, center_y, radius,
        output ready
    );
endinterface

interface circ_out_if #(
    parameter int COORD_WIDTH = circ_pkg::COORD_WIDTH,
    parameter int COLOR_WIDTH = circ_pkg::COLOR_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;
    logic [COLOR_WIDTH-1:0] pixel_color;
    logic                   last_of_step;
    logic                   circle_done;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_of_step, circle_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_of_step, circle_done,
        output ready
    );
endinterface

`default_nettype wire

/* design/circle_rasterizer.sv */
// circle rasterizer top level: config register, front end, step queue, back end
//
// Midpoint circle pixel generator with eight-way symmetry. A start item
// (operation 0) loads the centre and radius and produces nothing; each step
// item (operation 1) produces the eight mirrored pixels of the current octant
// point, in the order (x+a,y-b) (x+b,y-a) (x+b,y+a) (x+a,y+b) (x-a,y+b)
// (x-b,y+a) (x-a,y-b) (x-b,y-a), duplicates kept, and advances the point.
// The eighth pixel carries last_of_step, and on the final step of a circle
// also circle_done, after which further steps are ignored until the next
// start. Coordinates wrap modulo 2^COORD_WIDTH. Every pixel carries the pen
// colour held in the register at byte address 0 of the APB port. A step
// yields eight pixels, one pixel per cycle while the pixel channel is ready,
// sequenced by the back end's beat counter; start items and ignored steps
// queue nothing. The front end updates the circle state once per item and
// keeps running ahead of the back end while the two-entry step queue has room.
`default_nettype none

module circle_rasterizer #(
    parameter int COORD_WIDTH  = circ_pkg::COORD_WIDTH,
    parameter int RADIUS_WIDTH = circ_pkg::RADIUS_WIDTH,
    parameter int QUEUE_DEPTH  = circ_pkg::QUEUE_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [circ_pkg::PADDR_WIDTH-1:0] paddr,
    input  wire logic [circ_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic      [circ_pkg::PDATA_WIDTH-1:0] prdata,
    output logic                                  pready,
    // item channels
    circ_in_if.sink                               in_ch,
    circ_out_if.source                            out_ch
);
    localparam int CLW = circ_pkg::COLOR_WIDTH;
    // step record: centre, octant point, colour, final-step flag
    localparam int REC_WIDTH = 2 * COORD_WIDTH + 2 * RADIUS_WIDTH + CLW + 1;

    logic [CLW-1:0] pen_color_reg, pen_color_next;
    logic           cfg_write, pen_sel;

    logic                 push, push_ready, pop, pop_valid;
    logic [REC_WIDTH-1:0] push_data, pop_data;

    // register map, writes complete in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign pen_sel   = (paddr[circ_pkg::PADDR_WIDTH-1:2] == circ_pkg::REG_PEN_COLOR);

    assign pen_color_next = (cfg_write && pen_sel) ? pwdata[CLW-1:0] : pen_color_reg;
    assign prdata = pen_sel ? circ_pkg::PDATA_WIDTH'(pen_color_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_color_reg <= '0;
        end
        else
        begin
            pen_color_reg <= pen_color_next;
        end
    end

    // front: classifies items and steps the midpoint state
    circ_front #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RADIUS_WIDTH (RADIUS_WIDTH),
        .REC_WIDTH    (REC_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .pen_color  (pen_color_reg),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    // queue of pending steps, decouples the two sides
    circ_fifo #(
        .WIDTH (REC_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid)
    );

    // back: emits eight pixels per step record, back to back across records
    circ_back #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RADIUS_WIDTH (RADIUS_WIDTH),
        .REC_WIDTH    (REC_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

/* design/circ_fifo.sv */
// small register queue carrying step records from front to back
`default_nettype none

module circ_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = circ_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  push_ready,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  pop_valid
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* design/circ_front.sv */
// front end: takes items, holds the midpoint state and queues step records
`default_nettype none

module circ_front #(
    parameter int COORD_WIDTH  = circ_pkg::COORD_WIDTH,
    parameter int RADIUS_WIDTH = circ_pkg::RADIUS_WIDTH,
    parameter int REC_WIDTH    = 2 * COORD_WIDTH + 2 * RADIUS_WIDTH
                                 + circ_pkg::COLOR_WIDTH + 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    circ_in_if.sink                               in_ch,
    input  wire logic [circ_pkg::COLOR_WIDTH-1:0] pen_color,
    output logic                                  push,
    output logic [REC_WIDTH-1:0]                  push_data,
    input  wire logic                             push_ready
);
    localparam int AW = RADIUS_WIDTH + 1;   // a may reach radius + 1
    localparam int BW = RADIUS_WIDTH + 2;   // b signed, may fall to -1
    localparam int DW = RADIUS_WIDTH + 5;   // decision, signed
    localparam logic [DW-1:0] K3  = DW'(3);
    localparam logic [DW-1:0] K6  = DW'(6);
    localparam logic [DW-1:0] K10 = DW'(10);

    logic [COORD_WIDTH-1:0] cx_reg, cx_next;
    logic [COORD_WIDTH-1:0] cy_reg, cy_next;
    logic [AW-1:0]          a_reg, a_next;
    logic [BW-1:0]          b_reg, b_next;
    logic [DW-1:0]          d_reg, d_next;
    logic                   active_reg, active_next;

    logic          accept, is_step;
    logic [DW-1:0] a_ext, b_ext, d_step;
    logic [AW-1:0] a_step;
    logic [BW-1:0] b_step;
    logic          done;

    assign in_ch.ready = push_ready;
    assign accept  = in_ch.valid && push_ready;
    assign is_step = (circ_pkg::op_t'(in_ch.operation) == circ_pkg::OP_STEP);

    // one midpoint update
    always_comb
    begin
        a_ext  = DW'(a_reg);
        b_ext  = {{(DW - BW){b_reg[BW-1]}}, b_reg};
        a_step = a_reg + 1'b1;
        if (d_reg[DW-1])
        begin
            d_step = d_reg + {a_ext[DW-3:0], 2'b00} + K6;
            b_step = b_reg;
        end
        else
        begin
            d_step = d_reg + {a_ext[DW-3:0] - b_ext[DW-3:0], 2'b00} + K10;
            b_step = b_reg - 1'b1;
        end
        done = b_step[BW-1] || ({1'b0, a_step} > b_step);
    end

    assign push = accept && is_step && active_reg;
    assign push_data = {cx_reg, cy_reg, a_reg[RADIUS_WIDTH-1:0],
                        b_reg[RADIUS_WIDTH-1:0], pen_color, done};

    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        d_next      = d_reg;
        active_next = active_reg;
        if (accept)
        begin
            if (!is_step)
            begin
                cx_next     = in_ch.center_x;
                cy_next     = in_ch.center_y;
                a_next      = '0;
                b_next      = BW'(in_ch.radius);
                d_next      = K3 - DW'({in_ch.radius, 1'b0});
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                a_next      = a_step;
                b_next      = b_step;
                d_next      = d_step;
                active_next = !done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            d_reg      <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            d_reg      <= d_next;
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

/* design/circ_back.sv */
// back end: expands one step record into its eight symmetric pixel items
`default_nettype none

module circ_back #(
    parameter int COORD_WIDTH  = circ_pkg::COORD_WIDTH,
    parameter int RADIUS_WIDTH = circ_pkg::RADIUS_WIDTH,
    parameter int REC_WIDTH    = 2 * COORD_WIDTH + 2 * RADIUS_WIDTH
                                 + circ_pkg::COLOR_WIDTH + 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pop_valid,
    input  wire logic [REC_WIDTH-1:0] pop_data,
    output logic                      pop,
    circ_out_if.source                out_ch
);
    localparam int CLW = circ_pkg::COLOR_WIDTH;
    localparam logic [2:0] LAST_BEAT = 3'd7;

    logic [COORD_WIDTH-1:0]  cx_reg, cy_reg;
    logic [RADIUS_WIDTH-1:0] a_reg, b_reg;
    logic [CLW-1:0]          color_reg;
    logic                    done_reg;
    logic [2:0]              beat_reg, beat_next;
    logic                    busy_reg, busy_next;

    logic                   out_acc, last_beat;
    logic [COORD_WIDTH-1:0] a_c, b_c;

    assign out_acc   = busy_reg && out_ch.ready;
    assign last_beat = (beat_reg == LAST_BEAT);
    assign pop       = pop_valid && (!busy_reg || (out_acc && last_beat));

    always_comb
    begin
        beat_next = beat_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            beat_next = '0;
            busy_next = 1'b1;
        end
        else if (out_acc)
        begin
            if (last_beat)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                beat_next = beat_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            beat_reg <= beat_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            {cx_reg, cy_reg, a_reg, b_reg, color_reg, done_reg} <= pop_data;
        end
    end

    // octant mirror for the current beat
    always_comb
    begin
        a_c = COORD_WIDTH'(a_reg);
        b_c = COORD_WIDTH'(b_reg);
        case (beat_reg)
            3'd0:
            begin
                out_ch.pixel_x = cx_reg + a_c;
                out_ch.pixel_y = cy_reg - b_c;
            end
            3'd1:
            begin
                out_ch.pixel_x = cx_reg + b_c;
                out_ch.pixel_y = cy_reg - a_c;
            end
            3'd2:
            begin
                out_ch.pixel_x = cx_reg + b_c;
                out_ch.pixel_y = cy_reg + a_c;
            end
            3'd3:
            begin
                out_ch.pixel_x = cx_reg + a_c;
                out_ch.pixel_y = cy_reg + b_c;
            end
            3'd4:
            begin
                out_ch.pixel_x = cx_reg - a_c;
                out_ch.pixel_y = cy_reg + b_c;
            end
            3'd5:
            begin
                out_ch.pixel_x = cx_reg - b_c;
                out_ch.pixel_y = cy_reg + a_c;
            end
            3'd6:
            begin
                out_ch.pixel_x = cx_reg - a_c;
                out_ch.pixel_y = cy_reg - b_c;
            end
            default:
            begin
                out_ch.pixel_x = cx_reg - b_c;
                out_ch.pixel_y = cy_reg - a_c;
            end
        endcase
    end

    assign out_ch.valid        = busy_reg;
    assign out_ch.pixel_color  = color_reg;
    assign out_ch.last_of_step = last_beat;
    assign out_ch.circle_done  = last_beat && done_reg;

endmodule

`default_nettype wire
